>>> src/fpg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpg_pkg
// shared types and constants of the footstep pose generator
// ----------------------------------------------------------------------------
package fpg_pkg;

  localparam int MAX_STEPS_DEF = 64;
  localparam int STEP_CNT_W    = 7;

  localparam int A_W   = 22;
  localparam int B_W   = 18;
  localparam int ACC_W = A_W + B_W + 1;

  localparam int SEQ_LEN = 12;
  localparam int PH_W    = $clog2(SEQ_LEN);

  typedef enum logic [1:0] {
    MAC_HOLD,
    MAC_LOAD,
    MAC_ADD,
    MAC_SUB
  } mac_op_t;

  typedef enum logic [3:0] {
    OPS_NONE,
    OPS_H_S,
    OPS_H_TC,
    OPS_HC_DX,
    OPS_HS_DY,
    OPS_HS_DX,
    OPS_HC_DY,
    OPS_HC_C,
    OPS_HS_S,
    OPS_HS_C,
    OPS_HC_S
  } ops_t;

  typedef struct packed {
    ops_t    sel;
    mac_op_t op;
    logic    ld_ts;
    logic    ld_d;
    logic    ld_x;
    logic    ld_y;
    logic    ld_nc;
    logic    ld_head;
  } seq_ctl_t;

endpackage
`default_nettype wire

>>> src/fpg_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpg_mac
// shared signed multiply-accumulate unit, one product per cycle
// ----------------------------------------------------------------------------
module fpg_mac
  import fpg_pkg::*;
(
  input  logic                    clk,
  input  mac_op_t                 op,
  input  logic signed [A_W-1:0]   opnd_a,
  input  logic signed [B_W-1:0]   opnd_b,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;

  assign prod = ACC_W'(opnd_a * opnd_b);

  always_comb begin
    unique case (op)
      MAC_LOAD: acc_nxt = prod;
      MAC_ADD:  acc_nxt = acc_r + prod;
      MAC_SUB:  acc_nxt = acc_r - prod;
      default:  acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

>>> src/fpg_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpg_seq
// sequencer that walks the product schedule of one footstep update
// ----------------------------------------------------------------------------
module fpg_seq
  import fpg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output seq_ctl_t ctl
);

  logic            run_r;
  logic            run_nxt;
  logic [PH_W-1:0] ph_r;
  logic [PH_W-1:0] ph_nxt;
  logic            ph_end;

  assign ph_end = (ph_r == PH_W'(SEQ_LEN - 1));

  always_comb begin
    run_nxt = run_r;
    ph_nxt  = ph_r;
    if (start) begin
      run_nxt = 1'b1;
      ph_nxt  = '0;
    end else if (run_r) begin
      if (ph_end) begin
        run_nxt = 1'b0;
      end else begin
        ph_nxt = ph_r + PH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      ph_r  <= '0;
    end else begin
      run_r <= run_nxt;
      ph_r  <= ph_nxt;
    end
  end

  always_comb begin
    ctl = '{sel: OPS_NONE, op: MAC_HOLD, default: 1'b0};
    if (run_r) begin
      case (ph_r)
        PH_W'(0): begin
          ctl.sel = OPS_H_S;
          ctl.op  = MAC_LOAD;
        end
        PH_W'(1): begin
          ctl.ld_ts = 1'b1;
          ctl.sel   = OPS_H_TC;
          ctl.op    = MAC_LOAD;
        end
        PH_W'(2): begin
          ctl.ld_d = 1'b1;
        end
        PH_W'(3): begin
          ctl.sel = OPS_HC_DX;
          ctl.op  = MAC_LOAD;
        end
        PH_W'(4): begin
          ctl.sel = OPS_HS_DY;
          ctl.op  = MAC_SUB;
        end
        PH_W'(5): begin
          ctl.ld_x = 1'b1;
          ctl.sel  = OPS_HS_DX;
          ctl.op   = MAC_LOAD;
        end
        PH_W'(6): begin
          ctl.sel = OPS_HC_DY;
          ctl.op  = MAC_ADD;
        end
        PH_W'(7): begin
          ctl.ld_y = 1'b1;
          ctl.sel  = OPS_HC_C;
          ctl.op   = MAC_LOAD;
        end
        PH_W'(8): begin
          ctl.sel = OPS_HS_S;
          ctl.op  = MAC_SUB;
        end
        PH_W'(9): begin
          ctl.ld_nc = 1'b1;
          ctl.sel   = OPS_HS_C;
          ctl.op    = MAC_LOAD;
        end
        PH_W'(10): begin
          ctl.sel = OPS_HC_S;
          ctl.op  = MAC_ADD;
        end
        PH_W'(11): begin
          ctl.ld_head = 1'b1;
        end
        default: begin
          ctl.op = MAC_HOLD;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/footstep_pose_generator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// footstep_pose_generator_unit
// an input beat is taken only in idle; it goes to decode, then straight to push for
//   step zero or a finished plan, or through the twelve-phase schedule (ten products
//   on the shared mac) for a later step; push loads the output register and returns to
//   idle, waiting while a held result waits for out_tready
// reset (rst_n low, synchronous): control registers to defaults, pose cleared, plan at step zero
// ----------------------------------------------------------------------------
module footstep_pose_generator_unit
  import fpg_pkg::*;
#(
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] restart, [7:1] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [23:0] pos_x, [47:24] pos_y, [63:48] yaw,
                                  // [64] foot, [70:65] step_no, [71] zero
  output logic        out_tuser,  // [0] valid_res
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_STEPS + 1);
  localparam int LIM_W = (CNT_W > STEP_CNT_W) ? CNT_W : STEP_CNT_W;

  localparam logic signed [17:0] HEAD_ONE = 18'sd65536;
  localparam logic signed [B_W-1:0] TURN_ONE = B_W'(16384);
  localparam logic signed [ACC_W-1:0] RND14 = ACC_W'(2 ** 13);
  localparam logic signed [ACC_W-1:0] RND15 = ACC_W'(2 ** 14);
  localparam logic signed [ACC_W-1:0] RND16 = ACC_W'(2 ** 15);

  typedef enum logic [2:0] {
    CFG_STEP_LENGTH,
    CFG_FOOT_SPACING,
    CFG_TURN_COS,
    CFG_TURN_SIN,
    CFG_TURN_ANGLE,
    CFG_STEP_COUNT,
    CFG_FIRST_FOOT
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DEC  = 4'b0010,
    S_RUN  = 4'b0100,
    S_PUSH = 4'b1000
  } state_t;

  function automatic logic signed [23:0] sat_pos(input logic signed [25:0] v);
    if (v > 26'sd8388607) begin
      sat_pos = 24'sh7FFFFF;
    end else if (v < -26'sd8388608) begin
      sat_pos = 24'sh800000;
    end else begin
      sat_pos = v[23:0];
    end
  endfunction

  function automatic logic signed [17:0] sat_head(input logic signed [26:0] v);
    if (v > 27'sd131071) begin
      sat_head = 18'sh1FFFF;
    end else if (v < -27'sd131072) begin
      sat_head = 18'sh20000;
    end else begin
      sat_head = v[17:0];
    end
  endfunction

  // configuration registers
  logic signed [15:0] step_length_r;
  logic        [15:0] foot_spacing_r;
  logic signed [15:0] turn_cos_r;
  logic signed [15:0] turn_sin_r;
  logic        [15:0] turn_angle_r;
  logic        [6:0]  step_count_r;
  logic               first_foot_r;

  // pose and plan state
  state_t             state_r, state_nxt;
  logic signed [23:0] acc_x_r, acc_x_nxt;
  logic signed [23:0] acc_y_r, acc_y_nxt;
  logic signed [17:0] head_cos_r, head_cos_nxt;
  logic signed [17:0] head_sin_r, head_sin_nxt;
  logic        [15:0] acc_yaw_r, acc_yaw_nxt;
  logic [CNT_W-1:0]   steps_r, steps_nxt;
  logic               next_foot_r, next_foot_nxt;
  logic               fin_r, fin_nxt;

  // step temporaries
  logic signed [19:0] ts_r, ts_nxt;
  logic signed [19:0] dx_r, dx_nxt;
  logic signed [19:0] dy_r, dy_nxt;
  logic signed [17:0] nc_r, nc_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [71:0] out_data_r, out_data_nxt;
  logic        out_user_r, out_user_nxt;
  logic        out_last_r, out_last_nxt;

  seq_ctl_t                ctl;
  logic                    seq_start;
  logic signed [A_W-1:0]   opnd_a;
  logic signed [B_W-1:0]   opnd_b;
  logic signed [ACC_W-1:0] acc;

  logic [LIM_W-1:0]   cnt_ext;
  logic [LIM_W-1:0]   max_ext;
  logic [LIM_W-1:0]   lim;
  logic [LIM_W-1:0]   steps_ext;
  logic               plan_fin;
  logic               is_last;
  logic [15:0]        half_sp;
  logic signed [A_W-1:0] h_ext;
  logic signed [B_W-1:0] tcm;
  logic signed [19:0] l_ext;
  logic signed [19:0] h20;
  logic signed [ACC_W-1:0] r14_full;
  logic signed [ACC_W-1:0] r15_full;
  logic signed [ACC_W-1:0] r16_full;
  logic signed [25:0] r16_ext;
  logic               in_beat;
  logic               out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign in_beat    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_length_r  <= 16'sd328;
      foot_spacing_r <= 16'd6554;
      turn_cos_r     <= 16'sd16384;
      turn_sin_r     <= 16'sd0;
      turn_angle_r   <= 16'd0;
      step_count_r   <= 7'd20;
      first_foot_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STEP_LENGTH:  step_length_r  <= cfg_data;
        CFG_FOOT_SPACING: foot_spacing_r <= cfg_data;
        CFG_TURN_COS:     turn_cos_r     <= cfg_data;
        CFG_TURN_SIN:     turn_sin_r     <= cfg_data;
        CFG_TURN_ANGLE:   turn_angle_r   <= cfg_data;
        CFG_STEP_COUNT:   step_count_r   <= cfg_data[6:0];
        CFG_FIRST_FOOT:   first_foot_r   <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  // plan length and step position
  assign cnt_ext   = LIM_W'(step_count_r);
  assign max_ext   = LIM_W'(MAX_STEPS);
  assign lim       = (cnt_ext > max_ext) ? max_ext : cnt_ext;
  assign steps_ext = LIM_W'(steps_r);
  assign plan_fin  = (steps_ext >= lim);
  assign is_last   = ((steps_ext + LIM_W'(1)) == lim);
  assign half_sp   = 16'((17'(foot_spacing_r) + 17'd1) >> 1);

  // operand selection for the shared unit
  assign h_ext = $signed({{(A_W - 16){1'b0}}, foot_spacing_r});
  assign tcm   = $signed(B_W'(TURN_ONE)) - B_W'(turn_cos_r);

  always_comb begin
    opnd_a = '0;
    opnd_b = '0;
    case (ctl.sel)
      OPS_H_S: begin
        opnd_a = h_ext;
        opnd_b = B_W'(turn_sin_r);
      end
      OPS_H_TC: begin
        opnd_a = h_ext;
        opnd_b = tcm;
      end
      OPS_HC_DX: begin
        opnd_a = A_W'(dx_r);
        opnd_b = B_W'(head_cos_r);
      end
      OPS_HS_DY: begin
        opnd_a = A_W'(dy_r);
        opnd_b = B_W'(head_sin_r);
      end
      OPS_HS_DX: begin
        opnd_a = A_W'(dx_r);
        opnd_b = B_W'(head_sin_r);
      end
      OPS_HC_DY: begin
        opnd_a = A_W'(dy_r);
        opnd_b = B_W'(head_cos_r);
      end
      OPS_HC_C: begin
        opnd_a = A_W'(turn_cos_r);
        opnd_b = B_W'(head_cos_r);
      end
      OPS_HS_S: begin
        opnd_a = A_W'(turn_sin_r);
        opnd_b = B_W'(head_sin_r);
      end
      OPS_HS_C: begin
        opnd_a = A_W'(turn_cos_r);
        opnd_b = B_W'(head_sin_r);
      end
      OPS_HC_S: begin
        opnd_a = A_W'(turn_sin_r);
        opnd_b = B_W'(head_cos_r);
      end
      default: begin
        opnd_a = '0;
        opnd_b = '0;
      end
    endcase
  end

  fpg_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (seq_start),
    .ctl   (ctl)
  );

  fpg_mac u_mac (
    .clk    (clk),
    .op     (ctl.op),
    .opnd_a (opnd_a),
    .opnd_b (opnd_b),
    .acc    (acc)
  );

  // round half up by arithmetic shift
  assign r14_full = (acc + RND14) >>> 14;
  assign r15_full = (acc + RND15) >>> 15;
  assign r16_full = (acc + RND16) >>> 16;
  assign r16_ext  = r16_full[25:0];
  assign l_ext    = 20'(step_length_r);
  assign h20      = $signed({4'b0000, foot_spacing_r});

  always_comb begin
    state_nxt     = state_r;
    acc_x_nxt     = acc_x_r;
    acc_y_nxt     = acc_y_r;
    head_cos_nxt  = head_cos_r;
    head_sin_nxt  = head_sin_r;
    acc_yaw_nxt   = acc_yaw_r;
    steps_nxt     = steps_r;
    next_foot_nxt = next_foot_r;
    fin_nxt       = fin_r;
    ts_nxt        = ts_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    nc_nxt        = nc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;
    seq_start     = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (ctl.ld_ts) begin
      ts_nxt = r15_full[19:0];
    end
    if (ctl.ld_d) begin
      if (next_foot_r) begin
        dx_nxt = l_ext + ts_r;
        dy_nxt = r15_full[19:0] - h20;
      end else begin
        dx_nxt = l_ext - ts_r;
        dy_nxt = h20 - r15_full[19:0];
      end
    end
    if (ctl.ld_x) begin
      acc_x_nxt = sat_pos(26'(acc_x_r) + r16_ext);
    end
    if (ctl.ld_y) begin
      acc_y_nxt = sat_pos(26'(acc_y_r) + r16_ext);
    end
    if (ctl.ld_nc) begin
      nc_nxt = sat_head(r14_full[26:0]);
    end
    if (ctl.ld_head) begin
      head_cos_nxt = nc_r;
      head_sin_nxt = sat_head(r14_full[26:0]);
      acc_yaw_nxt  = acc_yaw_r + turn_angle_r;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          if (in_tdata[0]) begin
            acc_x_nxt     = '0;
            acc_y_nxt     = '0;
            head_cos_nxt  = HEAD_ONE;
            head_sin_nxt  = '0;
            acc_yaw_nxt   = '0;
            steps_nxt     = '0;
            next_foot_nxt = first_foot_r;
          end
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (plan_fin) begin
          fin_nxt   = 1'b1;
          state_nxt = S_PUSH;
        end else if (steps_r == '0) begin
          fin_nxt       = 1'b0;
          acc_x_nxt     = '0;
          acc_y_nxt     = first_foot_r ? -24'(half_sp) : 24'(half_sp);
          head_cos_nxt  = HEAD_ONE;
          head_sin_nxt  = '0;
          acc_yaw_nxt   = '0;
          next_foot_nxt = first_foot_r;
          state_nxt     = S_PUSH;
        end else begin
          fin_nxt   = 1'b0;
          seq_start = 1'b1;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (ctl.ld_head) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (fin_r) begin
            out_data_nxt = '0;
            out_user_nxt = 1'b0;
            out_last_nxt = 1'b0;
          end else begin
            out_data_nxt  = {1'b0, steps_ext[5:0], next_foot_r, acc_yaw_r,
                             acc_y_r, acc_x_r};
            out_user_nxt  = 1'b1;
            out_last_nxt  = is_last;
            steps_nxt     = steps_r + CNT_W'(1);
            next_foot_nxt = ~next_foot_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      head_cos_r  <= HEAD_ONE;
      head_sin_r  <= '0;
      acc_yaw_r   <= '0;
      steps_r     <= '0;
      next_foot_r <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_x_r     <= acc_x_nxt;
      acc_y_r     <= acc_y_nxt;
      head_cos_r  <= head_cos_nxt;
      head_sin_r  <= head_sin_nxt;
      acc_yaw_r   <= acc_yaw_nxt;
      steps_r     <= steps_nxt;
      next_foot_r <= next_foot_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ts_r       <= ts_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    nc_r       <= nc_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule
`default_nettype wire
